>>> hdl/ncpc_pkg.sv
// Shared types, widths and constant profile tables for the nearest-centroid
// profile classifier. No dependencies.
package ncpc_pkg;

    localparam int NUM_FEATURES = 6;
    localparam int ROM_ROWS     = 6;
    localparam int IDX_W        = 3;
    localparam int FEAT_W       = 16;
    localparam int VAL_W        = 18;
    localparam int SQ_W         = 2 * VAL_W;
    localparam int DIST_W       = 37;
    localparam int SQRT_W       = (DIST_W + 1) / 2;
    localparam int DEN_W        = SQRT_W + 1;
    localparam int NUM_W        = 33;
    localparam int QUO_W        = 17;
    localparam int CONF_W       = 16;

    // crest scaling: floor((16c + 3) / 6) as a reciprocal multiply
    localparam int CREST_X_W    = FEAT_W + 4;
    localparam int CREST_P_W    = 2 * CREST_X_W;
    localparam int CREST_SHIFT  = 22;
    localparam logic [CREST_X_W-1:0] CREST_RECIP = CREST_X_W'(699051);
    localparam logic [CREST_X_W-1:0] CREST_BIAS  = CREST_X_W'(3);
    localparam int CREST_IDX    = 2;

    localparam logic [DEN_W-1:0] DEN_BASE = DEN_W'(65536);
    localparam logic [CONF_W-1:0] CONF_MAX = '1;

    typedef logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat_vec_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } item_tag_t;

    typedef struct packed {
        logic [7:0]        spread;
        logic [7:0]        hrtf;
        logic signed [10:0] tilt;
        logic [7:0]        dyn;
        logic [7:0]        amb;
    } profile_attr_t;

    localparam logic [FEAT_W-1:0] CENTROID [ROM_ROWS][NUM_FEATURES] = '{
        '{16'd22282, 16'd11796, 16'd36045, 16'd40632, 16'd29491, 16'd45875},
        '{16'd26214, 16'd7864,  16'd29491, 16'd22938, 16'd22938, 16'd42598},
        '{16'd23593, 16'd14418, 16'd26214, 16'd39322, 16'd36045, 16'd49152},
        '{16'd21627, 16'd13107, 16'd11796, 16'd29491, 16'd26214, 16'd55706},
        '{16'd19661, 16'd10486, 16'd40632, 16'd36045, 16'd32768, 16'd36045},
        '{16'd29491, 16'd17039, 16'd14418, 16'd32768, 16'd39322, 16'd58982}
    };

    localparam profile_attr_t PROFILE_ATTR [ROM_ROWS] = '{
        '{8'd205, 8'd179, -11'sd256, 8'd230, 8'd141},
        '{8'd115, 8'd115, -11'sd512, 8'd205, 8'd102},
        '{8'd192, 8'd154,  11'sd256, 8'd179, 8'd154},
        '{8'd102, 8'd102,  11'sd128, 8'd102, 8'd77},
        '{8'd179, 8'd192, -11'sd128, 8'd243, 8'd179},
        '{8'd141, 8'd128,  11'sd384, 8'd128, 8'd90}
    };

endpackage

>>> hdl/nearest_centroid_profile_classifier_top.sv
// Nearest-centroid profile classifier: top level with stream ports and output register.
// One transaction per cycle while the output register is empty or being taken.
// Depth is set by the profile compare chain, 19 root stages and 17 quotient stages.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on ncpc_pkg, ncpc_dist, ncpc_sqrt and ncpc_div.
module nearest_centroid_profile_classifier_top #(
    parameter int NUM_PROFILES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bass_ratio, treble_ratio, crest_level, stereo_width, transient_rate,
    // spectral_density (16 bits each)
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // profile_index[2:0], confidence[18:3], spread_amount[26:19],
    // hrtf_amount[34:27], tilt_db[45:35], dyn_amount[53:46],
    // ambience_amount[61:54], zero[63:62]
    output logic [63:0] m_tdata
);

    logic en;

    ncpc_pkg::item_tag_t dist_tag;
    logic [ncpc_pkg::DIST_W-1:0] dist_val;
    ncpc_pkg::item_tag_t sqrt_tag;
    logic [ncpc_pkg::SQRT_W-1:0] sqrt_root;
    ncpc_pkg::item_tag_t div_tag;
    logic [ncpc_pkg::QUO_W-1:0] div_quot;

    ncpc_pkg::profile_attr_t attr;
    logic [ncpc_pkg::CONF_W-1:0] conf;

    logic        m_valid_reg;
    logic [63:0] m_data_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    ncpc_dist #(
        .NUM_PROFILES(NUM_PROFILES)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_feat  (s_tdata),
        .out_tag  (dist_tag),
        .out_dist (dist_val)
    );

    ncpc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (dist_tag),
        .in_val   (dist_val),
        .out_tag  (sqrt_tag),
        .out_root (sqrt_root)
    );

    ncpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (sqrt_tag),
        .in_root  (sqrt_root),
        .out_tag  (div_tag),
        .out_quot (div_quot)
    );

    assign attr = ncpc_pkg::PROFILE_ATTR[div_tag.idx];
    assign conf = (div_quot > ncpc_pkg::QUO_W'(ncpc_pkg::CONF_MAX))
                ? ncpc_pkg::CONF_MAX : div_quot[ncpc_pkg::CONF_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {2'b00, attr.amb, attr.dyn, attr.tilt, attr.hrtf,
                           attr.spread, conf, div_tag.idx};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/ncpc_dist.sv
// Distance pipeline: crest scaling, per-profile squared distances and a
// compare chain picking the nearest profile. Depends on ncpc_pkg.
module ncpc_dist #(
    parameter int NUM_PROFILES = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  ncpc_pkg::feat_vec_t            in_feat,
    output ncpc_pkg::item_tag_t            out_tag,
    output logic [ncpc_pkg::DIST_W-1:0]    out_dist
);

    localparam int NP = NUM_PROFILES;
    localparam int NF = ncpc_pkg::NUM_FEATURES;
    localparam int VW = ncpc_pkg::VAL_W;

    logic [ncpc_pkg::CREST_X_W-1:0] crest_x;
    logic [ncpc_pkg::CREST_P_W-1:0] crest_prod;

    logic [VW-1:0] val_reg [NF];
    logic          v1_reg;
    logic [VW-1:0] diff_next [NP][NF];
    logic [VW-1:0] diff_reg  [NP][NF];
    logic          v2_reg;
    logic [ncpc_pkg::SQ_W-1:0] sq_reg [NP][NF];
    logic          v3_reg;
    logic [ncpc_pkg::DIST_W-1:0] sum_next [NP];

    logic [ncpc_pkg::DIST_W-1:0] chain_dist_reg [NP][NP];
    logic [ncpc_pkg::DIST_W-1:0] chain_best_reg [NP];
    logic [ncpc_pkg::IDX_W-1:0]  chain_idx_reg  [NP];
    logic                        chain_v_reg    [NP];

    assign crest_x = {in_feat[ncpc_pkg::CREST_IDX], 4'b0000} + ncpc_pkg::CREST_BIAS;
    assign crest_prod = ncpc_pkg::CREST_P_W'(crest_x)
                      * ncpc_pkg::CREST_P_W'(ncpc_pkg::CREST_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NF; k++) begin
                if (k == ncpc_pkg::CREST_IDX) begin
                    val_reg[k] <= crest_prod[ncpc_pkg::CREST_SHIFT +: VW];
                end else begin
                    val_reg[k] <= VW'(in_feat[k]);
                end
            end
        end
    end

    always_comb begin
        logic [VW-1:0] c;
        for (int p = 0; p < NP; p++) begin
            for (int k = 0; k < NF; k++) begin
                c = VW'(ncpc_pkg::CENTROID[p][k]);
                diff_next[p][k] = (val_reg[k] >= c) ? (val_reg[k] - c) : (c - val_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            for (int p = 0; p < NP; p++) begin
                for (int k = 0; k < NF; k++) begin
                    sq_reg[p][k] <= ncpc_pkg::SQ_W'(diff_reg[p][k]) *
                                    ncpc_pkg::SQ_W'(diff_reg[p][k]);
                end
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NP; p++) begin
            sum_next[p] = '0;
            for (int k = 0; k < NF; k++) begin
                sum_next[p] = sum_next[p] + ncpc_pkg::DIST_W'(sq_reg[p][k]);
            end
        end
    end

    // chain head holds the sums, best seeded with profile 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_v_reg[0] <= 1'b0;
        end else if (en) begin
            chain_v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chain_dist_reg[0] <= sum_next;
            chain_best_reg[0] <= sum_next[0];
            chain_idx_reg[0]  <= '0;
        end
    end

    for (genvar j = 1; j < NP; j++) begin : g_cmp
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                chain_v_reg[j] <= 1'b0;
            end else if (en) begin
                chain_v_reg[j] <= chain_v_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                chain_dist_reg[j] <= chain_dist_reg[j-1];
                if (chain_dist_reg[j-1][j] < chain_best_reg[j-1]) begin
                    chain_best_reg[j] <= chain_dist_reg[j-1][j];
                    chain_idx_reg[j]  <= ncpc_pkg::IDX_W'(j);
                end else begin
                    chain_best_reg[j] <= chain_best_reg[j-1];
                    chain_idx_reg[j]  <= chain_idx_reg[j-1];
                end
            end
        end
    end

    assign out_tag.valid = chain_v_reg[NP-1];
    assign out_tag.idx   = chain_idx_reg[NP-1];
    assign out_dist      = chain_best_reg[NP-1];

endmodule

>>> hdl/ncpc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on ncpc_pkg.
module ncpc_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  ncpc_pkg::item_tag_t           in_tag,
    input  logic [ncpc_pkg::DIST_W-1:0]   in_val,
    output ncpc_pkg::item_tag_t           out_tag,
    output logic [ncpc_pkg::SQRT_W-1:0]   out_root
);

    localparam int S = ncpc_pkg::SQRT_W;

    ncpc_pkg::item_tag_t tag_reg  [S+1];
    logic [2*S-1:0]      x_reg    [S+1];
    logic [S+1:0]        rem_reg  [S+1];
    logic [S-1:0]        root_reg [S+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0].valid <= 1'b0;
        end else if (en) begin
            tag_reg[0].valid <= in_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0].idx <= in_tag.idx;
            x_reg[0]       <= (2*S)'(in_val);
            rem_reg[0]     <= '0;
            root_reg[0]    <= '0;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_stage
        logic [S+1:0] rem_sh;
        logic [S+1:0] trial;

        assign rem_sh = {rem_reg[i][S-1:0], x_reg[i][2*S-1 -: 2]};
        assign trial  = {root_reg[i], 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i+1].valid <= 1'b0;
            end else if (en) begin
                tag_reg[i+1].valid <= tag_reg[i].valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[i+1].idx <= tag_reg[i].idx;
                x_reg[i+1]       <= {x_reg[i][2*S-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[i+1]  <= rem_sh - trial;
                    root_reg[i+1] <= {root_reg[i][S-2:0], 1'b1};
                end else begin
                    rem_reg[i+1]  <= rem_sh;
                    root_reg[i+1] <= {root_reg[i][S-2:0], 1'b0};
                end
            end
        end
    end

    assign out_tag  = tag_reg[S];
    assign out_root = root_reg[S];

endmodule

>>> hdl/ncpc_div.sv
// Pipelined restoring divider for the confidence, round(2^32 / (65536 + s)),
// one quotient bit per stage. Depends on ncpc_pkg.
module ncpc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  ncpc_pkg::item_tag_t           in_tag,
    input  logic [ncpc_pkg::SQRT_W-1:0]   in_root,
    output ncpc_pkg::item_tag_t           out_tag,
    output logic [ncpc_pkg::QUO_W-1:0]    out_quot
);

    localparam int Q  = ncpc_pkg::QUO_W;
    localparam int DW = ncpc_pkg::DEN_W;
    localparam int NW = ncpc_pkg::NUM_W;

    logic [DW-1:0] den;
    logic [NW-1:0] num;

    ncpc_pkg::item_tag_t tag_reg [Q+1];
    logic [DW-1:0]       den_reg [Q+1];
    logic [DW:0]         rem_reg [Q+1];
    logic [Q-1:0]        lo_reg  [Q+1];
    logic [Q-1:0]        quo_reg [Q+1];

    assign den = DW'(in_root) + ncpc_pkg::DEN_BASE;
    assign num = {1'b1, {(NW-1){1'b0}}} + NW'(den >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0].valid <= 1'b0;
        end else if (en) begin
            tag_reg[0].valid <= in_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0].idx <= in_tag.idx;
            den_reg[0]     <= den;
            rem_reg[0]     <= (DW+1)'(num[NW-1:Q]);
            lo_reg[0]      <= num[Q-1:0];
            quo_reg[0]     <= '0;
        end
    end

    for (genvar i = 0; i < Q; i++) begin : g_stage
        logic [DW:0] rem_sh;

        assign rem_sh = {rem_reg[i][DW-1:0], lo_reg[i][Q-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i+1].valid <= 1'b0;
            end else if (en) begin
                tag_reg[i+1].valid <= tag_reg[i].valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[i+1].idx <= tag_reg[i].idx;
                den_reg[i+1]     <= den_reg[i];
                lo_reg[i+1]      <= {lo_reg[i][Q-2:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg[i]}) begin
                    rem_reg[i+1] <= rem_sh - {1'b0, den_reg[i]};
                    quo_reg[i+1] <= {quo_reg[i][Q-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= rem_sh;
                    quo_reg[i+1] <= {quo_reg[i][Q-2:0], 1'b0};
                end
            end
        end
    end

    assign out_tag  = tag_reg[Q];
    assign out_quot = quo_reg[Q];

endmodule
